### sv/sra_pkg.sv
// Package: sizes and field widths shared by the switch allocator.
`default_nettype none
package sra_pkg;

	localparam int NUM_INPORTS  = 5;
	localparam int NUM_OUTPORTS = 5;
	localparam int NUM_VCS      = 4;

	// Fixed slot widths of the packed fields
	localparam int PORT_W   = 3;
	localparam int INPORT_W = 3;
	localparam int VC_W     = 2;

	localparam int NUM_IVCS = NUM_INPORTS * NUM_VCS;

	typedef logic [VC_W-1:0]     vc_idx_t;
	typedef logic [INPORT_W-1:0] inport_idx_t;
	typedef logic [PORT_W-1:0]   port_idx_t;

endpackage
`default_nettype wire

### sv/separable_round_robin_switch_allocator_core.sv
// Separable input-first round-robin switch allocator for a router.
//
// Request channel (req_valid / req_ready): one cycle's request state per
// input VC: vc_ready_mask, vc_eligible_mask and the packed vc_target_ports.
// Grant channel (grant_valid / grant_ready): grant_valid_mask, the packed
// winning input port per output (grant_inports) and winning VC (grant_vcs).
//
// Each request is captured in the _s1 register; both allocation stages run
// on it as short combinational logic (per-input VC arbiters, then
// per-output port arbiters), and the grant set lands in the output register
// once that register is free or being taken. A new request can be accepted
// every cycle unless both stages are full: one request per cycle.
// The round-robin pointers advance only when a request moves from _s1 to
// the output register, so they stay in request order.
//
// When the receiver stalls, the grant is held in the output register and
// one more request is held in _s1; req_ready drops only when both are full.
// Reset (arst_n low) clears all pointers to zero and empties both stages.
`default_nettype none
module separable_round_robin_switch_allocator_core (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   req_valid,
	output logic                                  req_ready,
	input  wire  [sra_pkg::NUM_IVCS-1:0]          vc_ready_mask,
	input  wire  [sra_pkg::NUM_IVCS-1:0]          vc_eligible_mask,
	input  wire  [sra_pkg::NUM_IVCS*sra_pkg::PORT_W-1:0] vc_target_ports,
	output logic                                  grant_valid,
	input  wire                                   grant_ready,
	output logic [sra_pkg::NUM_OUTPORTS-1:0]      grant_valid_mask,
	output logic [sra_pkg::NUM_OUTPORTS*sra_pkg::INPORT_W-1:0] grant_inports,
	output logic [sra_pkg::NUM_OUTPORTS*sra_pkg::VC_W-1:0]     grant_vcs
);
	import sra_pkg::*;

	// Input stage
	logic                         valid_s1;
	logic [NUM_IVCS-1:0]          ready_s1;
	logic [NUM_IVCS-1:0]          eligible_s1;
	logic [NUM_IVCS*PORT_W-1:0]   targets_s1;

	// Round-robin pointers
	vc_idx_t     vc_ptr_q   [NUM_INPORTS];
	inport_idx_t port_ptr_q [NUM_OUTPORTS];
	vc_idx_t     vc_ptr_d   [NUM_INPORTS];
	inport_idx_t port_ptr_d [NUM_OUTPORTS];

	// Stage one winners
	logic      [NUM_INPORTS-1:0] win_valid;
	vc_idx_t   win_vc   [NUM_INPORTS];
	port_idx_t win_port [NUM_INPORTS];

	// Stage two grants
	logic [NUM_OUTPORTS-1:0]          gnt_valid;
	logic [NUM_OUTPORTS*INPORT_W-1:0] gnt_inports;
	logic [NUM_OUTPORTS*VC_W-1:0]     gnt_vcs;

	logic [NUM_IVCS-1:0] cand_mask;
	logic                advance;

	// Move s1 into the output register when the output is free or drains
	assign advance   = valid_s1 && (!grant_valid || grant_ready);
	assign req_ready = !valid_s1 || advance;
	assign cand_mask = ready_s1 & eligible_s1;

	// Stage one: each input port picks one VC, round robin from its pointer
	always_comb begin
		logic [VC_W:0] cand;
		vc_idx_t       vc;
		for (int ip = 0; ip < NUM_INPORTS; ip++) begin
			win_valid[ip] = 1'b0;
			win_vc[ip]    = '0;
			win_port[ip]  = '0;
			vc_ptr_d[ip]  = vc_ptr_q[ip];
			for (int k = 0; k < NUM_VCS; k++) begin
				cand = {1'b0, vc_ptr_q[ip]} + (VC_W+1)'(k);
				if (cand >= (VC_W+1)'(NUM_VCS)) begin
					cand = cand - (VC_W+1)'(NUM_VCS);
				end
				vc = cand[VC_W-1:0];
				if (!win_valid[ip] && cand_mask[ip*NUM_VCS + int'(vc)]) begin
					win_valid[ip] = 1'b1;
					win_vc[ip]    = vc;
					win_port[ip]  = targets_s1[(ip*NUM_VCS + int'(vc))*PORT_W +: PORT_W];
				end
			end
			// Advance past the winner even if it loses stage two
			if (win_valid[ip]) begin
				if (win_vc[ip] == VC_W'(NUM_VCS-1)) begin
					vc_ptr_d[ip] = '0;
				end else begin
					vc_ptr_d[ip] = win_vc[ip] + VC_W'(1);
				end
			end
		end
	end

	// Stage two: each output port grants one requesting input, round robin
	always_comb begin
		logic [INPORT_W:0] cand;
		inport_idx_t       sel;
		for (int op = 0; op < NUM_OUTPORTS; op++) begin
			gnt_valid[op]                      = 1'b0;
			gnt_inports[op*INPORT_W +: INPORT_W] = '0;
			gnt_vcs[op*VC_W +: VC_W]           = '0;
			port_ptr_d[op]                     = port_ptr_q[op];
			for (int k = 0; k < NUM_INPORTS; k++) begin
				cand = {1'b0, port_ptr_q[op]} + (INPORT_W+1)'(k);
				if (cand >= (INPORT_W+1)'(NUM_INPORTS)) begin
					cand = cand - (INPORT_W+1)'(NUM_INPORTS);
				end
				sel = cand[INPORT_W-1:0];
				// Out-of-range targets match no output and drop here
				if (!gnt_valid[op] && win_valid[sel] && win_port[sel] == PORT_W'(op)) begin
					gnt_valid[op]                      = 1'b1;
					gnt_inports[op*INPORT_W +: INPORT_W] = sel;
					gnt_vcs[op*VC_W +: VC_W]           = win_vc[sel];
				end
			end
			if (gnt_valid[op]) begin
				if (gnt_inports[op*INPORT_W +: INPORT_W] == INPORT_W'(NUM_INPORTS-1)) begin
					port_ptr_d[op] = '0;
				end else begin
					port_ptr_d[op] = gnt_inports[op*INPORT_W +: INPORT_W] + INPORT_W'(1);
				end
			end
		end
	end

	// Control: stage valids and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			grant_valid <= 1'b0;
			for (int ip = 0; ip < NUM_INPORTS; ip++) begin
				vc_ptr_q[ip] <= '0;
			end
			for (int op = 0; op < NUM_OUTPORTS; op++) begin
				port_ptr_q[op] <= '0;
			end
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				grant_valid <= 1'b1;
				vc_ptr_q    <= vc_ptr_d;
				port_ptr_q  <= port_ptr_d;
			end else if (grant_ready) begin
				grant_valid <= 1'b0;
			end
		end
	end

	// Payload: capture request, hold grant until taken
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			ready_s1    <= vc_ready_mask;
			eligible_s1 <= vc_eligible_mask;
			targets_s1  <= vc_target_ports;
		end
		if (advance) begin
			grant_valid_mask <= gnt_valid;
			grant_inports    <= gnt_inports;
			grant_vcs        <= gnt_vcs;
		end
	end

endmodule
`default_nettype wire

### bench/tb_separable_round_robin_switch_allocator_core.sv
// Testbench for the separable round-robin switch allocator core: directed and random requests.
`timescale 1ns / 1ps
module tb_separable_round_robin_switch_allocator_core;
	import sra_pkg::*;

	localparam int TARGETS_W = NUM_IVCS * PORT_W;

	// One grant set as the allocator returns it
	typedef struct packed {
		logic [NUM_OUTPORTS-1:0]          valid_mask;
		logic [NUM_OUTPORTS*INPORT_W-1:0] inports;
		logic [NUM_OUTPORTS*VC_W-1:0]     vcs;
	} grant_set_t;

	logic                     clk;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_ready;
	logic [NUM_IVCS-1:0]      vc_ready_mask;
	logic [NUM_IVCS-1:0]      vc_eligible_mask;
	logic [TARGETS_W-1:0]     vc_target_ports;
	logic                     grant_valid;
	logic                     grant_ready;
	logic [NUM_OUTPORTS-1:0]  grant_valid_mask;
	logic [NUM_OUTPORTS*INPORT_W-1:0] grant_inports;
	logic [NUM_OUTPORTS*VC_W-1:0]     grant_vcs;

	// Round-robin pointers of the predictor, in step with the block
	vc_idx_t     vc_ptr [NUM_INPORTS];
	inport_idx_t port_ptr [NUM_OUTPORTS];

	// Grant sets predicted for accepted requests, oldest first
	grant_set_t pending_grants [$];
	grant_set_t want;

	int error_count;
	int requests_sent;
	int directed_requests;
	int grants_checked;
	int port_grants;
	int dropped_winners;
	int sender_idle_pct;
	int recv_stall_pct;

	separable_round_robin_switch_allocator_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_ready        (req_ready),
		.vc_ready_mask    (vc_ready_mask),
		.vc_eligible_mask (vc_eligible_mask),
		.vc_target_ports  (vc_target_ports),
		.grant_valid      (grant_valid),
		.grant_ready      (grant_ready),
		.grant_valid_mask (grant_valid_mask),
		.grant_inports    (grant_inports),
		.grant_vcs        (grant_vcs)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: far beyond the slowest correct run
	initial begin
		#1000000;
		$display("separable_round_robin_switch_allocator_core test failed");
		$finish;
	end

	// Work out the grant set of one request and advance the pointers.
	// Stage one: each input picks its first ready and eligible VC from its pointer;
	// the pointer moves past the winner even when its target is out of range.
	// Stage two: each output grants the first requesting input from its pointer.
	function automatic grant_set_t predict_grants(input logic [NUM_IVCS-1:0] rdy,
			input logic [NUM_IVCS-1:0] elig, input logic [TARGETS_W-1:0] tgt);
		grant_set_t g;
		logic [NUM_INPORTS-1:0] asks [NUM_OUTPORTS];
		vc_idx_t ask_vc [NUM_OUTPORTS][NUM_INPORTS];
		int vc, idx, ip, won, port;
		g = '0;
		for (int op = 0; op < NUM_OUTPORTS; op++) begin
			asks[op] = '0;
			for (int i = 0; i < NUM_INPORTS; i++)
				ask_vc[op][i] = '0;
		end
		for (int i = 0; i < NUM_INPORTS; i++) begin
			won = 0;
			for (int k = 0; k < NUM_VCS; k++) begin
				vc = (int'(vc_ptr[i]) + k) % NUM_VCS;
				idx = i * NUM_VCS + vc;
				if (!won && rdy[idx] && elig[idx]) begin
					won = 1;
					port = int'(tgt[idx*PORT_W +: PORT_W]);
					if (port < NUM_OUTPORTS) begin
						asks[port][i] = 1'b1;
						ask_vc[port][i] = vc_idx_t'(vc);
					end else begin
						dropped_winners++;
					end
					vc_ptr[i] = vc_idx_t'((vc + 1) % NUM_VCS);
				end
			end
		end
		for (int op = 0; op < NUM_OUTPORTS; op++) begin
			won = 0;
			for (int k = 0; k < NUM_INPORTS; k++) begin
				ip = (int'(port_ptr[op]) + k) % NUM_INPORTS;
				if (!won && asks[op][ip]) begin
					won = 1;
					g.valid_mask[op] = 1'b1;
					g.inports[op*INPORT_W +: INPORT_W] = inport_idx_t'(ip);
					g.vcs[op*VC_W +: VC_W] = ask_vc[op][ip];
					port_ptr[op] = inport_idx_t'((ip + 1) % NUM_INPORTS);
					port_grants++;
				end
			end
		end
		return g;
	endfunction

	// Target slot of input ip, VC v is (base + v*vc_step + ip*ip_step) mod 8
	function automatic logic [TARGETS_W-1:0] pack_targets(input int base, input int vc_step,
			input int ip_step);
		logic [TARGETS_W-1:0] t;
		t = '0;
		for (int i = 0; i < NUM_INPORTS; i++)
			for (int v = 0; v < NUM_VCS; v++)
				t[(i*NUM_VCS+v)*PORT_W +: PORT_W] = port_idx_t'((base + v*vc_step + i*ip_step) % 8);
		return t;
	endfunction

	// Sparse, even or dense masks so that stage one sees every amount of contention
	function automatic logic [NUM_IVCS-1:0] rand_mask();
		logic [31:0] m;
		case ($urandom_range(2))
			0: m = $urandom & $urandom;
			1: m = $urandom;
			default: m = $urandom | $urandom;
		endcase
		return m[NUM_IVCS-1:0];
	endfunction

	// Mostly legal ports, some out of range, and now and then a hot spot on two outputs
	function automatic logic [TARGETS_W-1:0] rand_targets();
		logic [TARGETS_W-1:0] t;
		int hot;
		hot = ($urandom_range(3) == 0);
		for (int s = 0; s < NUM_IVCS; s++) begin
			if ($urandom_range(9) == 0)
				t[s*PORT_W +: PORT_W] = port_idx_t'($urandom_range(7, NUM_OUTPORTS));
			else if (hot)
				t[s*PORT_W +: PORT_W] = port_idx_t'($urandom_range(1));
			else
				t[s*PORT_W +: PORT_W] = port_idx_t'($urandom_range(NUM_OUTPORTS - 1));
		end
		return t;
	endfunction

	// Send one request. Entered just after a rising edge; returns at the rising edge
	// that accepts it. Valid stays high afterwards so back-to-back requests need no gap.
	task automatic send_request(input logic [NUM_IVCS-1:0] rdy, input logic [NUM_IVCS-1:0] elig,
			input logic [TARGETS_W-1:0] tgt);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		vc_ready_mask = rdy;
		vc_eligible_mask = elig;
		vc_target_ports = tgt;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		pending_grants.push_back(predict_grants(rdy, elig, tgt));
		requests_sent++;
	endtask

	// Hold off the sender until every predicted grant has come back, then let the
	// pipeline settle.
	task automatic drain_grants();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Receiver: stall at the rate of the current phase
	always @(negedge clk) begin
		grant_ready = ($urandom_range(99) >= recv_stall_pct);
	end

	// Check each accepted grant set against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && grant_valid && grant_ready) begin
			if (pending_grants.size() == 0) begin
				error_count++;
				$display("%0t: unexpected grant set mask=%h inports=%h vcs=%h", $time,
					grant_valid_mask, grant_inports, grant_vcs);
			end else begin
				want = pending_grants.pop_front();
				grants_checked++;
				if (grant_valid_mask !== want.valid_mask) begin
					error_count++;
					$display("%0t: grant_valid_mask expected %h actual %h", $time,
						want.valid_mask, grant_valid_mask);
				end
				if (grant_inports !== want.inports) begin
					error_count++;
					$display("%0t: grant_inports expected %h actual %h", $time,
						want.inports, grant_inports);
				end
				if (grant_vcs !== want.vcs) begin
					error_count++;
					$display("%0t: grant_vcs expected %h actual %h", $time,
						want.vcs, grant_vcs);
				end
			end
		end
	end

	// Empty, full and one-sided masks; all-ones targets are all out of range
	task automatic test_field_extremes();
		send_request('0, '0, '0);
		send_request('1, '1, '1);
		send_request('1, '0, pack_targets(0, 0, 0));
		send_request('0, '1, pack_targets(0, 0, 0));
	endtask

	// Ready but not eligible VCs must be skipped by stage one
	task automatic test_ineligible_skip();
		logic [NUM_IVCS-1:0] vc2_only;
		logic [NUM_IVCS-1:0] vc3_only;
		vc2_only = '0;
		vc3_only = '0;
		for (int i = 0; i < NUM_INPORTS; i++) begin
			vc2_only[i*NUM_VCS + 2] = 1'b1;
			vc3_only[i*NUM_VCS + 3] = 1'b1;
		end
		send_request('1, vc2_only, pack_targets(0, 0, 1));
		send_request(~vc3_only, vc3_only, pack_targets(0, 0, 1));
	endtask

	// Every VC asks for output 0: output pointer and VC pointers rotate
	task automatic test_pointer_rotation();
		repeat (6) send_request('1, '1, pack_targets(0, 0, 0));
	endtask

	// VC 0..2 target ports 5..7 and VC 3 targets port 0: stage-one winners
	// with no real port still move the VC pointer, and their request is dropped
	task automatic test_out_of_range_targets();
		repeat (4) send_request('1, '1, pack_targets(NUM_OUTPORTS, 1, 0));
	endtask

	// Input i aims at output 4-i so all five outputs grant at once
	task automatic test_full_grant_set();
		repeat (2) send_request('1, '1, pack_targets(4, 0, 7));
	endtask

	task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n) send_request(rand_mask(), rand_mask(), rand_targets());
		// Pause the sender until the block has returned every grant
		drain_grants();
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		vc_ready_mask = '0;
		vc_eligible_mask = '0;
		vc_target_ports = '0;
		grant_ready = 1'b0;
		error_count = 0;
		requests_sent = 0;
		grants_checked = 0;
		port_grants = 0;
		dropped_winners = 0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < NUM_INPORTS; i++)
			vc_ptr[i] = '0;
		for (int i = 0; i < NUM_OUTPORTS; i++)
			port_ptr[i] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_ineligible_skip();
		test_pointer_rotation();
		test_out_of_range_targets();
		test_full_grant_set();
		drain_grants();
		directed_requests = requests_sent;

		test_random_traffic(300, 0, 0);
		test_random_traffic(300, 69, 0);
		test_random_traffic(300, 0, 69);
		test_random_traffic(300, 12, 12);

		$display("Covered %0d requests (%0d directed) under four idle/stall mixes;",
			requests_sent, directed_requests);
		$display("checked %0d grant sets, %0d port grants, %0d out-of-range winners dropped",
			grants_checked, port_grants, dropped_winners);
		if (error_count == 0 && pending_grants.size() == 0)
			$display("separable_round_robin_switch_allocator_core test passed");
		else
			$display("separable_round_robin_switch_allocator_core test failed");
		$finish;
	end

endmodule

### separable_round_robin_switch_allocator_core.f
sv/sra_pkg.sv
sv/separable_round_robin_switch_allocator_core.sv
bench/tb_separable_round_robin_switch_allocator_core.sv
